// ----- rtl/sqrlt_pkg.sv -----
// Shared types and constants for the square/retransmit loss tracker.
// No dependencies; every other file of the block but the checker refers to it by scoped names.
package sqrlt_pkg;

  // Reset value of the half period length register.
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd64;
  localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

  // The divider produces quotient bits 24..0; anything at or above 2^25 is overflow.
  localparam int unsigned QUO_BITS = 25;
  localparam int unsigned STEP_W   = 5;

  localparam logic [23:0] RATIO_SMAX = 24'h7FFFFF;
  localparam logic [23:0] RATIO_SMIN = 24'h800000;
  localparam logic [23:0] RATIO_UMAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

// ----- rtl/square_retransmit_loss_tracker.sv -----
// Square-bit and retransmit-bit loss tracker, one tracker per direction.
// Each word passes the load, divide and finish states before out_valid, and the next
// is taken once its result is handed off (bit-serial ratio dividers, one quotient bit
// per cycle, 25 bits). Reset (rst_n low, synchronous) clears the trackers, the output
// valid and sets half_period_length to 64. Config writes are always ready.
module square_retransmit_loss_tracker #(
  parameter int unsigned RATIO_FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_half_period_length,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_from_responder,
  input  logic               in_square_bit,
  input  logic               in_retransmit_bit,
  input  logic [31:0]        in_side_packet_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_direction,
  output logic               out_half_period_ended,
  output logic signed [31:0] out_square_loss_total,
  output logic [31:0]        out_retransmit_loss_total,
  output logic signed [23:0] out_square_loss_ratio,
  output logic [23:0]        out_retransmit_loss_ratio,
  output logic               out_zero_count
);

  sqrlt_pkg::dp_cmd_t    cmd;
  sqrlt_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  sqrlt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  sqrlt_dp #(.FRAC_BITS(RATIO_FRACTION_BITS)) u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .status                    (status),
    .cfg_we                    (cfg_valid && cfg_ready),
    .cfg_half_period_length    (cfg_half_period_length),
    .in_from_responder         (in_from_responder),
    .in_square_bit             (in_square_bit),
    .in_retransmit_bit         (in_retransmit_bit),
    .in_side_packet_count      (in_side_packet_count),
    .out_direction             (out_direction),
    .out_half_period_ended     (out_half_period_ended),
    .out_square_loss_total     (out_square_loss_total),
    .out_retransmit_loss_total (out_retransmit_loss_total),
    .out_square_loss_ratio     (out_square_loss_ratio),
    .out_retransmit_loss_ratio (out_retransmit_loss_ratio),
    .out_zero_count            (out_zero_count)
  );

endmodule

// ----- rtl/sqrlt_div.sv -----
// Bit-serial restoring divider for (mag << FRAC_BITS) / divisor, 25 quotient bits.
// Flags overflow when the quotient reaches 2^25. Uses sqrlt_pkg.
module sqrlt_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                load,
  input  logic                                step,
  input  logic [31:0]                         mag,
  input  logic [31:0]                         divisor,
  output logic [sqrlt_pkg::QUO_BITS-1:0]      quo,
  output logic                                ovf
);

  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned QB = sqrlt_pkg::QUO_BITS;
  localparam int unsigned HW = NW - QB;

  logic [NW-1:0] n_full;
  logic [31:0]   hi_ext;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   div_r;
  logic [QB-1:0] nbits_r, nbits_nxt;
  logic [QB-1:0] quo_r, quo_nxt;
  logic          ovf_r, ovf_nxt;
  logic [32:0]   rem_sh;
  logic [32:0]   rem_diff;
  logic          ge;

  assign n_full = {mag, {FRAC_BITS{1'b0}}};
  assign hi_ext = {{(32 - HW){1'b0}}, n_full[NW-1:QB]};

  assign rem_sh   = {rem_r, nbits_r[QB-1]};
  assign ge       = rem_sh >= {1'b0, div_r};
  assign rem_diff = rem_sh - {1'b0, div_r};

  always_comb begin
    rem_nxt   = rem_r;
    nbits_nxt = nbits_r;
    quo_nxt   = quo_r;
    ovf_nxt   = ovf_r;
    if (load) begin
      // The quotient overflows exactly when the top part already reaches the divisor.
      ovf_nxt   = hi_ext >= divisor;
      rem_nxt   = hi_ext;
      nbits_nxt = n_full[QB-1:0];
      quo_nxt   = '0;
    end else if (step) begin
      rem_nxt   = ge ? rem_diff[31:0] : rem_sh[31:0];
      nbits_nxt = {nbits_r[QB-2:0], 1'b0};
      quo_nxt   = {quo_r[QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    nbits_r <= nbits_nxt;
    quo_r   <= quo_nxt;
    ovf_r   <= ovf_nxt;
    if (load) begin
      div_r <= divisor;
    end
  end

  assign quo = quo_r;
  assign ovf = ovf_r;

endmodule

// ----- rtl/sqrlt_dp.sv -----
// Datapath: per-direction trackers, config register, two ratio dividers, output word.
// Driven by sqrlt_ctrl commands; uses sqrlt_pkg and sqrlt_div.
module sqrlt_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sqrlt_pkg::dp_cmd_t    cmd,
  output sqrlt_pkg::dp_status_t status,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_half_period_length,
  input  logic                  in_from_responder,
  input  logic                  in_square_bit,
  input  logic                  in_retransmit_bit,
  input  logic [31:0]           in_side_packet_count,
  output logic                  out_direction,
  output logic                  out_half_period_ended,
  output logic signed [31:0]    out_square_loss_total,
  output logic [31:0]           out_retransmit_loss_total,
  output logic signed [23:0]    out_square_loss_ratio,
  output logic [23:0]           out_retransmit_loss_ratio,
  output logic                  out_zero_count
);

  localparam int unsigned QB = sqrlt_pkg::QUO_BITS;
  localparam int unsigned SW = sqrlt_pkg::STEP_W;

  logic [15:0]        hp_len_r;
  logic               cur_sq_r   [2];
  logic               cur_sq_nxt [2];
  logic [15:0]        hp_cnt_r   [2];
  logic [15:0]        hp_cnt_nxt [2];
  logic               seen_r     [2];
  logic               seen_nxt   [2];
  logic signed [31:0] sq_sum_r   [2];
  logic signed [31:0] sq_sum_nxt [2];
  logic [31:0]        rt_sum_r   [2];
  logic [31:0]        rt_sum_nxt [2];

  logic               d_r;
  logic               ended_r;
  logic               zero_r;
  logic [31:0]        count_r;
  logic [SW-1:0]      step_cnt_r;

  logic               d;
  logic signed [33:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic               ended;

  logic signed [31:0] sel_sum;
  logic               sel_neg;
  logic [31:0]        sq_mag;
  logic [QB-1:0]      sq_quo, rt_quo;
  logic               sq_ovf, rt_ovf;
  logic [23:0]        sq_ratio, rt_ratio;

  assign d = in_from_responder;

  // Half period close: add (length - count), saturated to the signed 32-bit range.
  assign sum_wide = {{2{sq_sum_r[d][31]}}, sq_sum_r[d]}
                  + {18'b0, hp_len_r} - {18'b0, hp_cnt_r[d]};

  always_comb begin
    if (sum_wide[33:31] == 3'b000 || sum_wide[33:31] == 3'b111) begin
      sum_sat = sum_wide[31:0];
    end else if (sum_wide[33]) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = 32'sh7FFF_FFFF;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      cur_sq_nxt[i] = cur_sq_r[i];
      hp_cnt_nxt[i] = hp_cnt_r[i];
      seen_nxt[i]   = seen_r[i];
      sq_sum_nxt[i] = sq_sum_r[i];
      rt_sum_nxt[i] = rt_sum_r[i];
    end
    ended = 1'b0;
    if (cmd.accept) begin
      priority if (hp_cnt_r[d] == 16'd0 && !seen_r[d]) begin
        cur_sq_nxt[d] = in_square_bit;
        hp_cnt_nxt[d] = 16'd1;
      end else if (in_square_bit == cur_sq_r[d]) begin
        if (hp_cnt_r[d] != sqrlt_pkg::COUNT_MAX) begin
          hp_cnt_nxt[d] = hp_cnt_r[d] + 16'd1;
        end
      end else begin
        sq_sum_nxt[d] = sum_sat;
        cur_sq_nxt[d] = in_square_bit;
        hp_cnt_nxt[d] = 16'd1;
        seen_nxt[d]   = 1'b1;
        ended         = 1'b1;
      end
      if (in_retransmit_bit && rt_sum_r[d] != 32'hFFFF_FFFF) begin
        rt_sum_nxt[d] = rt_sum_r[d] + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_len_r <= sqrlt_pkg::HALF_PERIOD_RESET;
      for (int i = 0; i < 2; i++) begin
        cur_sq_r[i] <= 1'b0;
        hp_cnt_r[i] <= 16'd0;
        seen_r[i]   <= 1'b0;
        sq_sum_r[i] <= 32'sd0;
        rt_sum_r[i] <= 32'd0;
      end
    end else begin
      if (cfg_we) begin
        hp_len_r <= cfg_half_period_length;
      end
      for (int i = 0; i < 2; i++) begin
        cur_sq_r[i] <= cur_sq_nxt[i];
        hp_cnt_r[i] <= hp_cnt_nxt[i];
        seen_r[i]   <= seen_nxt[i];
        sq_sum_r[i] <= sq_sum_nxt[i];
        rt_sum_r[i] <= rt_sum_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      d_r     <= d;
      ended_r <= ended;
      zero_r  <= in_side_packet_count == 32'd0;
      count_r <= in_side_packet_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      step_cnt_r <= '0;
    end else if (cmd.step) begin
      step_cnt_r <= step_cnt_r + SW'(1);
    end
  end

  assign status.div_last = step_cnt_r == SW'(QB - 1);

  // The tracker of d_r holds still until the next word is accepted.
  assign sel_sum = sq_sum_r[d_r];
  assign sel_neg = sel_sum[31];
  assign sq_mag  = sel_neg ? (~sel_sum + 32'd1) : sel_sum;

  sqrlt_div #(.FRAC_BITS(FRAC_BITS)) u_sq_div (
    .clk     (clk),
    .load    (cmd.load),
    .step    (cmd.step),
    .mag     (sq_mag),
    .divisor (count_r),
    .quo     (sq_quo),
    .ovf     (sq_ovf)
  );

  sqrlt_div #(.FRAC_BITS(FRAC_BITS)) u_rt_div (
    .clk     (clk),
    .load    (cmd.load),
    .step    (cmd.step),
    .mag     (rt_sum_r[d_r]),
    .divisor (count_r),
    .quo     (rt_quo),
    .ovf     (rt_ovf)
  );

  // A zero count always raises overflow in the dividers, which gives the saturated ratios.
  always_comb begin
    if (sel_neg) begin
      if (sq_ovf || sq_quo[24] || (sq_quo[23] && sq_quo[22:0] != 23'd0)) begin
        sq_ratio = sqrlt_pkg::RATIO_SMIN;
      end else begin
        sq_ratio = ~sq_quo[23:0] + 24'd1;
      end
    end else begin
      if (sq_ovf || sq_quo[24] || sq_quo[23]) begin
        sq_ratio = sqrlt_pkg::RATIO_SMAX;
      end else begin
        sq_ratio = sq_quo[23:0];
      end
    end
    rt_ratio = (rt_ovf || rt_quo[24]) ? sqrlt_pkg::RATIO_UMAX : rt_quo[23:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_direction             <= d_r;
      out_half_period_ended     <= ended_r;
      out_square_loss_total     <= sel_sum;
      out_retransmit_loss_total <= rt_sum_r[d_r];
      out_square_loss_ratio     <= sq_ratio;
      out_retransmit_loss_ratio <= rt_ratio;
      out_zero_count            <= zero_r;
    end
  end

endmodule

// ----- rtl/sqrlt_ctrl.sv -----
// Controller state machine: accepts a word, runs the divider steps, hands off the result.
// Talks to sqrlt_dp through command and status structs from sqrlt_pkg.
module sqrlt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sqrlt_pkg::dp_cmd_t    cmd,
  input  sqrlt_pkg::dp_status_t status
);

  sqrlt_pkg::ctrl_state_t state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqrlt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      sqrlt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sqrlt_pkg::ST_LOAD;
        end
      end
      sqrlt_pkg::ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = sqrlt_pkg::ST_DIV;
      end
      sqrlt_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_nxt = sqrlt_pkg::ST_FIN;
        end
      end
      sqrlt_pkg::ST_FIN: begin
        // Wait here only while the previous word still sits stalled in the output register.
        if (!out_valid_r || !out_stall) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sqrlt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sqrlt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/sqrlt_checker.sv -----
// Port-level checker for the loss tracker, attached to the top level by bind.
// Depends only on the top level's ports.
module sqrlt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_square_loss_total,
  input logic signed [23:0] out_square_loss_ratio,
  input logic [23:0]        out_retransmit_loss_ratio,
  input logic               out_zero_count
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // The block works on one word at a time, so it stalls right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again directly after an accept");

  // A zero packet count always saturates the retransmit ratio.
  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_count |-> out_retransmit_loss_ratio == 24'hFFFFFF)
    else $error("zero packet count without saturated retransmit ratio");

  // A non-negative loss total gives a non-negative square loss ratio.
  a_ratio_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_square_loss_total[31] |-> !out_square_loss_ratio[23])
    else $error("negative loss ratio for a non-negative loss total");

endmodule

bind square_retransmit_loss_tracker sqrlt_checker u_sqrlt_checker (
  .clk                       (clk),
  .rst_n                     (rst_n),
  .in_valid                  (in_valid),
  .in_stall                  (in_stall),
  .out_valid                 (out_valid),
  .out_stall                 (out_stall),
  .out_square_loss_total     (out_square_loss_total),
  .out_square_loss_ratio     (out_square_loss_ratio),
  .out_retransmit_loss_ratio (out_retransmit_loss_ratio),
  .out_zero_count            (out_zero_count)
);
